// ===== rtl/assert_macros.svh =====
// Assertion macros for the RTL file that checks its own behavior.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at the rising clock edge.
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked at the rising clock edge.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/sitd_pkg.sv =====
// Shared types and constants of the signed integer to decimal text block.
package sitd_pkg;

   localparam logic [5:0] CODE_MINUS  = 6'd45;
   localparam logic [5:0] CODE_ZERO   = 6'd48;
   localparam logic [5:0] CODE_NINE   = 6'd57;
   localparam logic [1:0] DIGIT_HIGH  = 2'b11;   // upper bits of '0'..'9'
   localparam logic [3:0] BCD_ADJ_MIN = 4'd5;
   localparam logic [3:0] BCD_ADJ_ADD = 4'd3;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;         // take a new value, clear the BCD word
      logic conv_step;    // one double-dabble bit step
      logic norm_shift;   // drop a leading zero digit
      logic emit_digit;   // advance to the next digit after showing one
      logic sel_sign;     // show '-' instead of the top digit
   } dp_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic conv_last;    // this conversion step is the final bit
      logic norm_done;    // top digit nonzero or only one digit left
      logic emit_last;    // the digit on display is the final one
      logic neg;          // value is negative
   } dp_status_type;

endpackage

// ===== rtl/sitd_datapath.sv =====
// Datapath: magnitude, bit-serial binary-to-BCD, leading-zero strip, character mux.
module sitd_datapath #(
   parameter int VALUE_BITS = 32
) (
   input  logic                         clock,
   input  logic signed [VALUE_BITS-1:0] req_value,
   input  sitd_pkg::dp_cmd_type         cmd,
   output sitd_pkg::dp_status_type      status,
   output logic [5:0]                   rsp_char_code,
   output logic                         rsp_last_char,
   output logic [3:0]                   rsp_char_count
);

   // Decimal digits needed for a VALUE_BITS-bit magnitude.
   localparam int NDIG = (VALUE_BITS * 30103) / 100000 + 1;
   localparam int BW   = $clog2(VALUE_BITS + 1);
   localparam int CW   = $clog2(NDIG + 1);
   localparam int TW   = (CW + 1 > 4) ? CW + 1 : 4;

   logic [VALUE_BITS-1:0] mag_ff, mag_in;
   logic [4*NDIG-1:0]     bcd_ff, bcd_in, bcd_adj;
   logic [BW-1:0]         bit_cnt_ff, bit_cnt_in;
   logic [CW-1:0]         dig_cnt_ff, dig_cnt_in;
   logic [CW-1:0]         rem_ff, rem_in;
   logic                  neg_ff, neg_in;
   logic [3:0]            top_digit;
   logic [TW-1:0]         total;
   logic [VALUE_BITS-1:0] value_u;

   assign value_u   = $unsigned(req_value);
   assign top_digit = bcd_ff[4*NDIG-1 -: 4];

   // Add-3 correction on every digit, all in parallel.
   always_comb begin
      for (int i = 0; i < NDIG; i++) begin
         if (bcd_ff[4*i +: 4] >= sitd_pkg::BCD_ADJ_MIN) begin
            bcd_adj[4*i +: 4] = bcd_ff[4*i +: 4] + sitd_pkg::BCD_ADJ_ADD;
         end else begin
            bcd_adj[4*i +: 4] = bcd_ff[4*i +: 4];
         end
      end
   end

   always_comb begin
      mag_in     = mag_ff;
      bcd_in     = bcd_ff;
      bit_cnt_in = bit_cnt_ff;
      dig_cnt_in = dig_cnt_ff;
      rem_in     = rem_ff;
      neg_in     = neg_ff;
      if (cmd.load) begin
         neg_in     = value_u[VALUE_BITS-1];
         mag_in     = value_u[VALUE_BITS-1] ?
                      (~value_u + {{(VALUE_BITS-1){1'b0}}, 1'b1}) : value_u;
         bcd_in     = '0;
         bit_cnt_in = BW'(VALUE_BITS);
         dig_cnt_in = CW'(NDIG);
         rem_in     = CW'(NDIG);
      end else if (cmd.conv_step) begin
         bcd_in     = {bcd_adj[4*NDIG-2:0], mag_ff[VALUE_BITS-1]};
         mag_in     = {mag_ff[VALUE_BITS-2:0], 1'b0};
         bit_cnt_in = bit_cnt_ff - BW'(1);
      end else if (cmd.norm_shift) begin
         bcd_in     = {bcd_ff[4*NDIG-5:0], 4'b0000};
         dig_cnt_in = dig_cnt_ff - CW'(1);
         rem_in     = rem_ff - CW'(1);
      end else if (cmd.emit_digit) begin
         bcd_in     = {bcd_ff[4*NDIG-5:0], 4'b0000};
         rem_in     = rem_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      mag_ff     <= mag_in;
      bcd_ff     <= bcd_in;
      bit_cnt_ff <= bit_cnt_in;
      dig_cnt_ff <= dig_cnt_in;
      rem_ff     <= rem_in;
      neg_ff     <= neg_in;
   end

   assign total = TW'(dig_cnt_ff) + TW'(neg_ff);

   assign status.conv_last = (bit_cnt_ff == BW'(1));
   assign status.norm_done = (top_digit != 4'd0) || (dig_cnt_ff == CW'(1));
   assign status.emit_last = (rem_ff == CW'(1));
   assign status.neg       = neg_ff;

   assign rsp_char_code  = cmd.sel_sign ? sitd_pkg::CODE_MINUS
                                        : {sitd_pkg::DIGIT_HIGH, top_digit};
   assign rsp_last_char  = !cmd.sel_sign && (rem_ff == CW'(1));
   assign rsp_char_count = total[3:0];

endmodule

// ===== rtl/sitd_ctrl.sv =====
// Controller: sequences load, conversion, zero strip, sign and digit transfers.
module sitd_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  sitd_pkg::dp_status_type status,
   output sitd_pkg::dp_cmd_type    cmd,
   output logic                    busy,
   output logic                    rsp_valid
);

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_CONV = 5'b00010,
      ST_NORM = 5'b00100,
      ST_SIGN = 5'b01000,
      ST_EMIT = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      rsp_valid = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_CONV;
            end
         end
         ST_CONV: begin
            cmd.conv_step = 1'b1;
            if (status.conv_last) state_in = ST_NORM;
         end
         ST_NORM: begin
            if (status.norm_done) begin
               state_in = status.neg ? ST_SIGN : ST_EMIT;
            end else begin
               cmd.norm_shift = 1'b1;
            end
         end
         ST_SIGN: begin
            rsp_valid    = 1'b1;
            cmd.sel_sign = 1'b1;
            state_in     = ST_EMIT;
         end
         ST_EMIT: begin
            rsp_valid      = 1'b1;
            cmd.emit_digit = 1'b1;
            if (status.emit_last) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

// ===== rtl/signed_int_to_decimal_ascii.sv =====
// Top level: signed integer to decimal ASCII text, one character per transfer.
//
//   Channel   Ports                                  Direction  Handshake
//   request   start, busy, req_value                 in         start && !busy
//   response  rsp_valid, rsp_char_code,              out        rsp_valid strobe,
//             rsp_last_char, rsp_char_count                     one cycle, no stall
//
// Sequence: a load step, VALUE_BITS double-dabble steps (one bit per cycle
// through the shared add-3 row), up to NDIG-1 steps stripping leading zeros
// plus a step that finds the top digit, then the characters in order (sign
// first when negative). Stripped zeros and digits always add up to NDIG.
// busy is high from the accepting edge until the last character's cycle ends.
// Reset is synchronous, active high, and returns the controller to idle.
// The receiver cannot stall: each character is a single-cycle transfer.
`include "assert_macros.svh"

module signed_int_to_decimal_ascii #(
   parameter int VALUE_BITS = 32
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic signed [VALUE_BITS-1:0] req_value,
   output logic                         rsp_valid,
   output logic [5:0]                   rsp_char_code,
   output logic                         rsp_last_char,
   output logic [3:0]                   rsp_char_count
);

   sitd_pkg::dp_cmd_type    cmd;
   sitd_pkg::dp_status_type status;
   logic                    char_legal;

   // Controller: one-hot sequencer, owns busy and the response strobe.
   sitd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .status    (status),
      .cmd       (cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   // Datapath: magnitude, BCD shift register, digit counters, output mux.
   sitd_datapath #(
      .VALUE_BITS (VALUE_BITS)
   ) u_dp (
      .clock          (clock),
      .req_value      (req_value),
      .cmd            (cmd),
      .status         (status),
      .rsp_char_code  (rsp_char_code),
      .rsp_last_char  (rsp_last_char),
      .rsp_char_count (rsp_char_count)
   );

   // '-' or a decimal digit.
   assign char_legal = (rsp_char_code == sitd_pkg::CODE_MINUS) ||
                       ((rsp_char_code >= sitd_pkg::CODE_ZERO) &&
                        (rsp_char_code <= sitd_pkg::CODE_NINE));

   // A character only goes out while an item is in flight.
   `ASSERT_IMPLY(a_rsp_while_busy, clock, reset, rsp_valid, busy, "response while idle")
   // The last character frees the block on the next cycle.
   `ASSERT_NEXT(a_last_frees, clock, reset, rsp_valid && rsp_last_char, !busy, "busy after last")
   // An accepted request makes the block busy.
   `ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy, "accept not busy")
   // Only '-' or a decimal digit ever appears.
   `ASSERT_IMPLY(a_char_legal, clock, reset, rsp_valid, char_legal, "bad character")

endmodule
